// ===== src/bilinear_table_interpolator_core_macros.svh =====
// Assertion macros for the bilinear table interpolator.
`ifndef BILINEAR_TABLE_INTERPOLATOR_CORE_MACROS_SVH
`define BILINEAR_TABLE_INTERPOLATOR_CORE_MACROS_SVH

`ifndef SYNTHESIS
`define BTINT_ASSERT(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
	else $error("btint assertion failed");
`define BTINT_ASSERT_ALWAYS(lbl, clk, prop) \
	lbl: assert property (@(posedge clk) prop) \
	else $error("btint assertion failed");
`else
`define BTINT_ASSERT(lbl, clk, rstn, prop)
`define BTINT_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

// ===== src/btint_pkg.sv =====
package btint_pkg;

	localparam logic [1:0] KIND_BP     = 2'd0;
	localparam logic [1:0] KIND_XTAB   = 2'd1;
	localparam logic [1:0] KIND_YTAB   = 2'd2;
	localparam logic [1:0] KIND_LOOKUP = 2'd3;

	localparam logic REG_POINTS = 1'b0;
	localparam logic REG_RES    = 1'b1;

	localparam int CNT_W     = 7;
	localparam int DIV_STEPS = 25;
	localparam int Q_W       = 25;
	localparam int AX_W      = 25;
	localparam int NUM_W     = 41;
	localparam int P_W       = 57;

	typedef struct packed {
		logic [1:0]         kind;
		logic [3:0]         table_row;
		logic [3:0]         table_col;
		logic signed [7:0]  table_value;
		logic signed [15:0] in_x;
		logic signed [15:0] in_y;
	} item_t;

	typedef struct packed {
		logic               in_range;
		logic signed [23:0] out_x;
		logic signed [23:0] out_y;
	} result_t;

	typedef struct packed {
		logic             capture;
		logic             scan;
		logic             check;
		logic             tread;
		logic             mul1;
		logic             mul2;
		logic             mul3;
		logic             prep;
		logic             div_step;
		logic             load_out;
		logic [CNT_W-1:0] cnt;
	} cmd_t;

	typedef struct packed {
		logic scan_last;
		logic bad;
		logic out_free;
	} sts_t;

endpackage

// ===== src/btint_ctrl.sv =====
`include "bilinear_table_interpolator_core_macros.svh"

module btint_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            item_valid,
	input  logic [1:0]      item_kind,
	output logic            item_stall,
	input  btint_pkg::sts_t sts,
	output btint_pkg::cmd_t cmd
);
	import btint_pkg::*;

	localparam logic [3:0] ST_IDLE     = 4'd0;
	localparam logic [3:0] ST_SCAN     = 4'd1;
	localparam logic [3:0] ST_SCAN_END = 4'd2;
	localparam logic [3:0] ST_CHECK    = 4'd3;
	localparam logic [3:0] ST_TREAD    = 4'd4;
	localparam logic [3:0] ST_TWAIT    = 4'd5;
	localparam logic [3:0] ST_MUL1     = 4'd6;
	localparam logic [3:0] ST_MUL2     = 4'd7;
	localparam logic [3:0] ST_MUL3     = 4'd8;
	localparam logic [3:0] ST_PREP     = 4'd9;
	localparam logic [3:0] ST_DIV      = 4'd10;
	localparam logic [3:0] ST_OUT      = 4'd11;

	logic [3:0]       state_q, state_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;
	logic             accept;

	assign item_stall = (state_q != ST_IDLE);
	assign accept     = item_valid && !item_stall;

	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		cmd     = '0;
		cmd.cnt = cnt_q;
		unique case (state_q)
			ST_IDLE: begin
				cmd.capture = accept;
				cnt_d = '0;
				if (accept && item_kind == KIND_LOOKUP) state_d = ST_SCAN;
			end
			ST_SCAN: begin
				cmd.scan = 1'b1;
				cnt_d = cnt_q + 1'b1;
				if (sts.scan_last) state_d = ST_SCAN_END;
			end
			ST_SCAN_END: state_d = ST_CHECK;
			ST_CHECK: begin
				cmd.check = 1'b1;
				cnt_d = '0;
				state_d = sts.bad ? ST_OUT : ST_TREAD;
			end
			ST_TREAD: begin
				cmd.tread = 1'b1;
				cnt_d = cnt_q + 1'b1;
				if (cnt_q == CNT_W'(3)) state_d = ST_TWAIT;
			end
			ST_TWAIT: state_d = ST_MUL1;
			ST_MUL1: begin
				cmd.mul1 = 1'b1;
				state_d = ST_MUL2;
			end
			ST_MUL2: begin
				cmd.mul2 = 1'b1;
				state_d = ST_MUL3;
			end
			ST_MUL3: begin
				cmd.mul3 = 1'b1;
				state_d = ST_PREP;
			end
			ST_PREP: begin
				cmd.prep = 1'b1;
				cnt_d = '0;
				state_d = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				cnt_d = cnt_q + 1'b1;
				if (cnt_q == CNT_W'(DIV_STEPS - 1)) state_d = ST_OUT;
			end
			ST_OUT: begin
				if (sts.out_free) begin
					cmd.load_out = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	`BTINT_ASSERT(a_lookup_blocks, clk, arst_n, accept && item_kind == KIND_LOOKUP |=> item_stall)
	`BTINT_ASSERT(a_load_needs_room, clk, arst_n, cmd.load_out |-> sts.out_free)
	`BTINT_ASSERT(a_div_bound, clk, arst_n, state_q == ST_DIV |-> cnt_q < CNT_W'(DIV_STEPS))
	`BTINT_ASSERT(a_load_ends, clk, arst_n, cmd.load_out |=> !item_stall)
endmodule

// ===== src/btint_dp.sv =====
module btint_dp #(
	parameter int MAX_POINTS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  btint_pkg::item_t  item,
	input  logic              cfg_we,
	input  logic              cfg_index,
	input  logic [15:0]       cfg_data,
	input  btint_pkg::cmd_t   cmd,
	output btint_pkg::sts_t   sts,
	output logic              res_valid,
	input  logic              res_stall,
	output btint_pkg::result_t res
);
	import btint_pkg::*;

	localparam int PW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int AW = $clog2(MAX_POINTS * MAX_POINTS);
	localparam int NW = $clog2(MAX_POINTS + 1);

	// configuration
	logic [4:0]  points_q;
	logic [15:0] res_q;
	logic [NW-1:0] n_eff, nm1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			points_q <= 5'd16;
			res_q    <= 16'd256;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_POINTS: points_q <= cfg_data[4:0];
				REG_RES:    res_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		if (points_q < 5'd2) n_eff = NW'(2);
		else if (32'(points_q) > 32'(MAX_POINTS)) n_eff = NW'(MAX_POINTS);
		else n_eff = NW'(points_q);
	end
	assign nm1 = n_eff - 1'b1;
	assign sts.scan_last = (cmd.cnt == CNT_W'(nm1));

	// memories
	logic signed [7:0] bp_mem [MAX_POINTS];
	logic signed [7:0] xt_mem [MAX_POINTS*MAX_POINTS];
	logic signed [7:0] yt_mem [MAX_POINTS*MAX_POINTS];
	logic signed [7:0] bp_rd_q, xt_rd_q, yt_rd_q;
	logic [AW-1:0]     wr_addr, rd_addr;
	logic [PW-1:0]     rd_row, rd_col;
	logic              row_ok, col_ok;

	assign row_ok  = CNT_W'(item.table_row) < CNT_W'(MAX_POINTS);
	assign col_ok  = CNT_W'(item.table_col) < CNT_W'(MAX_POINTS);
	assign wr_addr = AW'(PW'(item.table_row)) * AW'(MAX_POINTS) + AW'(PW'(item.table_col));

	logic [PW-1:0] ix_q, jy_q;
	assign rd_row  = jy_q + PW'(cmd.cnt[1]);
	assign rd_col  = ix_q + PW'(cmd.cnt[0]);
	assign rd_addr = AW'(rd_row) * AW'(MAX_POINTS) + AW'(rd_col);

	always_ff @(posedge clk) begin
		if (cmd.capture && item.kind == KIND_BP && row_ok)
			bp_mem[PW'(item.table_row)] <= item.table_value;
		if (cmd.capture && item.kind == KIND_XTAB && row_ok && col_ok)
			xt_mem[wr_addr] <= item.table_value;
		if (cmd.capture && item.kind == KIND_YTAB && row_ok && col_ok)
			yt_mem[wr_addr] <= item.table_value;
		bp_rd_q <= bp_mem[cmd.cnt[PW-1:0]];
		xt_rd_q <= xt_mem[rd_addr];
		yt_rd_q <= yt_mem[rd_addr];
	end

	// point capture and bracket scan
	logic signed [15:0] x_q, y_q;
	logic signed [7:0]  fx, fy, lo_q, hi_q, bx0_q, bx1_q, by0_q, by1_q;
	logic               pend_x_q, pend_y_q, scan_vld_s1, sel_x, sel_y, not_last;
	logic [CNT_W-1:0]   scan_k_s1;

	assign fx = x_q[15:8];
	assign fy = y_q[15:8];
	assign not_last = scan_k_s1 < CNT_W'(nm1);
	assign sel_x = not_last && (bp_rd_q <= fx);
	assign sel_y = not_last && (bp_rd_q <= fy);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_vld_s1 <= 1'b0;
			pend_x_q    <= 1'b0;
			pend_y_q    <= 1'b0;
		end else begin
			scan_vld_s1 <= cmd.scan;
			if (cmd.capture) begin
				pend_x_q <= 1'b0;
				pend_y_q <= 1'b0;
			end else if (scan_vld_s1) begin
				pend_x_q <= sel_x;
				pend_y_q <= sel_y;
			end
		end
	end

	always_ff @(posedge clk) begin
		scan_k_s1 <= cmd.cnt;
		if (cmd.capture) begin
			x_q  <= item.in_x;
			y_q  <= item.in_y;
			ix_q <= '0;
			jy_q <= '0;
		end
		if (scan_vld_s1) begin
			if (scan_k_s1 == '0) lo_q <= bp_rd_q;
			if (scan_k_s1 == CNT_W'(nm1)) hi_q <= bp_rd_q;
			if (pend_x_q) bx1_q <= bp_rd_q;
			if (pend_y_q) by1_q <= bp_rd_q;
			if (sel_x) begin
				ix_q  <= scan_k_s1[PW-1:0];
				bx0_q <= bp_rd_q;
			end
			if (sel_y) begin
				jy_q  <= scan_k_s1[PW-1:0];
				by0_q <= bp_rd_q;
			end
		end
	end

	assign sts.bad = (fx < lo_q) || (fx >= hi_q) || (fy < lo_q) || (fy >= hi_q) ||
		(bx1_q <= bx0_q) || (by1_q <= by0_q);

	// distances to the bracket edges
	logic [15:0] dx1_q, dx2_q, dy1_q, dy2_q;
	logic        ok_q;
	logic signed [17:0] dx1_c, dx2_c, dy1_c, dy2_c;

	assign dx1_c = 18'(x_q) - {{2{bx0_q[7]}}, bx0_q, 8'b0};
	assign dx2_c = {{2{bx1_q[7]}}, bx1_q, 8'b0} - 18'(x_q);
	assign dy1_c = 18'(y_q) - {{2{by0_q[7]}}, by0_q, 8'b0};
	assign dy2_c = {{2{by1_q[7]}}, by1_q, 8'b0} - 18'(y_q);

	always_ff @(posedge clk) begin
		if (cmd.check) begin
			ok_q  <= !sts.bad;
			dx1_q <= dx1_c[15:0];
			dx2_q <= dx2_c[15:0];
			dy1_q <= dy1_c[15:0];
			dy2_q <= dy2_c[15:0];
		end
	end

	// corner fetch
	logic              tr_vld_s1;
	logic [1:0]        tr_c_s1;
	logic signed [7:0] qx_q [4];
	logic signed [7:0] qy_q [4];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) tr_vld_s1 <= 1'b0;
		else tr_vld_s1 <= cmd.tread;
	end

	always_ff @(posedge clk) begin
		tr_c_s1 <= cmd.cnt[1:0];
		if (tr_vld_s1) begin
			qx_q[tr_c_s1] <= xt_rd_q;
			qy_q[tr_c_s1] <= yt_rd_q;
		end
	end

	// products
	logic signed [16:0] sdx1, sdx2, sdy1, sdy2;
	logic signed [AX_W-1:0] ax0_q, ax1_q, ay0_q, ay1_q;
	logic [31:0] d_q;
	logic signed [NUM_W-1:0] numx_q, numy_q;
	logic signed [P_W-1:0] px_q, py_q;

	assign sdx1 = $signed({1'b0, dx1_q});
	assign sdx2 = $signed({1'b0, dx2_q});
	assign sdy1 = $signed({1'b0, dy1_q});
	assign sdy2 = $signed({1'b0, dy2_q});

	always_ff @(posedge clk) begin
		if (cmd.mul1) begin
			ax0_q <= AX_W'(qx_q[0] * sdx2) + AX_W'(qx_q[1] * sdx1);
			ax1_q <= AX_W'(qx_q[2] * sdx2) + AX_W'(qx_q[3] * sdx1);
			ay0_q <= AX_W'(qy_q[0] * sdx2) + AX_W'(qy_q[1] * sdx1);
			ay1_q <= AX_W'(qy_q[2] * sdx2) + AX_W'(qy_q[3] * sdx1);
			d_q   <= 32'(({1'b0, dx1_q} + {1'b0, dx2_q}) * ({1'b0, dy1_q} + {1'b0, dy2_q}));
		end
		if (cmd.mul2) begin
			numx_q <= NUM_W'(ax0_q * sdy2) + NUM_W'(ax1_q * sdy1);
			numy_q <= NUM_W'(ay0_q * sdy2) + NUM_W'(ay1_q * sdy1);
		end
		if (cmd.mul3) begin
			px_q <= P_W'(numx_q * $signed({1'b0, res_q}));
			py_q <= P_W'(numy_q * $signed({1'b0, res_q}));
		end
	end

	// rounding division, one quotient bit per cycle for both tables
	logic [P_W-1:0] remx_q, remy_q, ds_q, magx, magy;
	logic [Q_W-1:0] qtx_q, qty_q;
	logic           negx_q, negy_q, gex, gey;

	assign magx = (px_q[P_W-1] ? P_W'(-px_q) : P_W'(px_q)) + P_W'(d_q[31:1]);
	assign magy = (py_q[P_W-1] ? P_W'(-py_q) : P_W'(py_q)) + P_W'(d_q[31:1]);
	assign gex  = remx_q >= ds_q;
	assign gey  = remy_q >= ds_q;

	always_ff @(posedge clk) begin
		if (cmd.prep) begin
			remx_q <= magx;
			remy_q <= magy;
			negx_q <= px_q[P_W-1];
			negy_q <= py_q[P_W-1];
			ds_q   <= P_W'({d_q, {(DIV_STEPS-1){1'b0}}});
			qtx_q  <= '0;
			qty_q  <= '0;
		end else if (cmd.div_step) begin
			if (gex) remx_q <= remx_q - ds_q;
			if (gey) remy_q <= remy_q - ds_q;
			qtx_q <= {qtx_q[Q_W-2:0], gex};
			qty_q <= {qty_q[Q_W-2:0], gey};
			ds_q  <= ds_q >> 1;
		end
	end

	function automatic logic signed [23:0] finish(input logic [Q_W-1:0] q, input logic neg);
		logic signed [Q_W+1:0] s, r;
		s = neg ? -$signed({2'b0, q}) : $signed({2'b0, q});
		r = s + (Q_W+2)'(65536);
		if (r > (Q_W+2)'(8388607)) return 24'sh7FFFFF;
		else if (r < -(Q_W+2)'(8388608)) return 24'sh800000;
		else return r[23:0];
	endfunction

	// result register
	logic    full_q;
	result_t res_q_out;

	assign sts.out_free = !full_q || !res_stall;
	assign res_valid    = full_q;
	assign res          = res_q_out;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) full_q <= 1'b0;
		else if (cmd.load_out) full_q <= 1'b1;
		else if (!res_stall) full_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			res_q_out.in_range <= ok_q;
			res_q_out.out_x    <= ok_q ? finish(qtx_q, negx_q) : '0;
			res_q_out.out_y    <= ok_q ? finish(qty_q, negy_q) : '0;
		end
	end
endmodule

// ===== src/bilinear_table_interpolator_core.sv =====
// Bilinear table interpolator.
// Input channel (item_valid / item_stall / item): kinds 0..2 load one
// breakpoint or one x/y table byte; they produce no result and leave item_stall low.
// Kind 3 is a lookup of a signed Q8.8 point and produces exactly one result.
// Output channel (res_valid / res_stall / res): in_range plus signed Q8.16
// x and y factors, saturated; an out-of-range point returns all zeros.
// A lookup scans the breakpoint memory one entry per cycle over the n
// breakpoints in use, fetches the four table corners, runs the multiply
// steps mul1, mul2 and mul3, and a shared restoring divider then produces
// one quotient bit per cycle, 25 bits for each of x and y.
// One lookup is in flight at a time; item_stall is high while it runs.
// The result sits in an output register, so the next item is taken while a
// finished result waits; a lookup that finishes while res_stall holds the
// previous result waits until that register frees.
// Config (cfg_we / cfg_index / cfg_data): index 0 points_in_use, index 1
// lut_resolution; write only while idle.
// Reset clears control and sets config (16 points, resolution 256); tables and
// breakpoints hold nothing until loaded.
module bilinear_table_interpolator_core #(
	parameter int MAX_POINTS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_stall,
	input  btint_pkg::item_t    item,
	output logic                res_valid,
	input  logic                res_stall,
	output btint_pkg::result_t  res,
	input  logic                cfg_we,
	input  logic                cfg_index,
	input  logic [15:0]         cfg_data
);
	import btint_pkg::*;

	cmd_t cmd;
	sts_t sts;

	btint_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_kind  (item.kind),
		.item_stall (item_stall),
		.sts        (sts),
		.cmd        (cmd)
	);

	btint_dp #(
		.MAX_POINTS (MAX_POINTS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.sts       (sts),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);
endmodule

// ===== test/tb_top.sv =====
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import btint_pkg::*;

	localparam int  NPTS      = 16;
	localparam int  SETTLE    = 80;
	localparam int  RAND_ITEMS = 300;
	localparam longint LIMIT  = 1000000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        item_valid = 1'b0;
	logic        item_stall;
	item_t       item = '0;
	logic        res_valid;
	logic        res_stall = 1'b0;
	result_t     res;
	logic        cfg_we = 1'b0;
	logic        cfg_index = REG_POINTS;
	logic [15:0] cfg_data = '0;

	bilinear_table_interpolator_core dut (
		.clk(clk), .arst_n(arst_n),
		.item_valid(item_valid), .item_stall(item_stall), .item(item),
		.res_valid(res_valid), .res_stall(res_stall), .res(res),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	// shadow of the block's state
	int          bp_mem [NPTS];
	int          xtab [NPTS*NPTS];
	int          ytab [NPTS*NPTS];
	logic [4:0]  pts_reg = 5'd16;
	logic [15:0] res_reg = 16'd256;

	result_t     lookup_q [$];
	int          errs = 0;
	longint      cyc = 0;
	int          burst_left = 0;
	bit          hold_req = 0;
	bit          hold_done = 0;
	int          hold_left = 0;
	int          seg_left = 0;
	int          seg_mode = 0;

	typedef struct {
		item_t   it;
		bit      known;
		result_t want;
	} row_t;

	row_t dir_rows [$];

	always @(posedge clk) begin
		cyc <= cyc + 1;
		if (cyc > LIMIT) begin
			$display("tb_top NOT OK");
			$finish;
		end
	end

	function automatic item_t mk(logic [1:0] k, int r, int c, int v, int x, int y);
		item_t t;
		t.kind = k;
		t.table_row = r[3:0];
		t.table_col = c[3:0];
		t.table_value = v[7:0];
		t.in_x = x[15:0];
		t.in_y = y[15:0];
		return t;
	endfunction

	function automatic int axis_bracket(int f, int n);
		int idx;
		idx = 0;
		for (int k = 0; k + 1 < n; k++)
			if (bp_mem[k] <= f)
				idx = k;
		return idx;
	endfunction

	function automatic logic signed [23:0] blend(bit use_y, int i, int j,
			longint dx1, longint dx2, longint dy1, longint dy2);
		longint q00, q01, q10, q11, num, d, p, mag, q, r;
		q00 = use_y ? ytab[j*NPTS+i]       : xtab[j*NPTS+i];
		q01 = use_y ? ytab[j*NPTS+i+1]     : xtab[j*NPTS+i+1];
		q10 = use_y ? ytab[(j+1)*NPTS+i]   : xtab[(j+1)*NPTS+i];
		q11 = use_y ? ytab[(j+1)*NPTS+i+1] : xtab[(j+1)*NPTS+i+1];
		num = q00*dx2*dy2 + q01*dx1*dy2 + q10*dx2*dy1 + q11*dx1*dy1;
		d = (dx1 + dx2) * (dy1 + dy2);
		p = num * longint'(res_reg);
		mag = p < 0 ? -p : p;
		q = (mag + d / 2) / d;
		r = (p < 0 ? -q : q) + 65536;
		if (r > 8388607) r = 8388607;
		if (r < -8388608) r = -8388608;
		return r[23:0];
	endfunction

	// applies one accepted item to the shadow state; returns 1 for a lookup
	function automatic bit interp_lookup(item_t it, output result_t r);
		int v, xq, yq, fx, fy, n, lo, hi, i, j;
		longint dx1, dx2, dy1, dy2;
		v = int'($signed(it.table_value));
		r = '0;
		case (it.kind)
			KIND_BP: begin
				bp_mem[it.table_row] = v;
				return 0;
			end
			KIND_XTAB: begin
				xtab[it.table_row*NPTS + it.table_col] = v;
				return 0;
			end
			KIND_YTAB: begin
				ytab[it.table_row*NPTS + it.table_col] = v;
				return 0;
			end
			default: ;
		endcase
		xq = int'($signed(it.in_x));
		yq = int'($signed(it.in_y));
		fx = xq >>> 8;
		fy = yq >>> 8;
		n = pts_reg;
		if (n < 2) n = 2;
		if (n > NPTS) n = NPTS;
		lo = bp_mem[0];
		hi = bp_mem[n-1];
		if (fx < lo || fx >= hi || fy < lo || fy >= hi)
			return 1;
		i = axis_bracket(fx, n);
		j = axis_bracket(fy, n);
		if (bp_mem[i+1] <= bp_mem[i] || bp_mem[j+1] <= bp_mem[j])
			return 1;
		dx1 = longint'(xq) - longint'(bp_mem[i]) * 256;
		dx2 = longint'(bp_mem[i+1]) * 256 - xq;
		dy1 = longint'(yq) - longint'(bp_mem[j]) * 256;
		dy2 = longint'(bp_mem[j+1]) * 256 - yq;
		r.in_range = 1'b1;
		r.out_x = blend(0, i, j, dx1, dx2, dy1, dy2);
		r.out_y = blend(1, i, j, dx1, dx2, dy1, dy2);
		return 1;
	endfunction

	// offers one item, keeping valid high across bursts
	task automatic send(item_t it, bit known = 0, result_t want = '0);
		int gap;
		result_t r;
		gap = 0;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 30);
			gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12);
		end
		burst_left--;
		if (gap > 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item <= it;
		item_valid <= 1'b1;
		do @(posedge clk); while (item_stall);
		if (interp_lookup(it, r))
			lookup_q.push_back(known ? want : r);
	endtask

	task automatic drain();
		item_valid <= 1'b0;
		while (lookup_q.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [15:0] d);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_POINTS)
			pts_reg = d[4:0];
		else
			res_reg = d;
		@(posedge clk);
	endtask

	task automatic load_axis(bit fixed_grid);
		int b;
		b = fixed_grid ? -120 : -128 + int'($urandom_range(0, 20));
		for (int k = 0; k < NPTS; k++) begin
			send(mk(KIND_BP, k, 0, b, 0, 0));
			b += fixed_grid ? 15 : int'($urandom_range(1, 15));
		end
	endtask

	task automatic rand_item();
		int n, lo, hi, sel;
		n = pts_reg < 2 ? 2 : (pts_reg > NPTS ? NPTS : pts_reg);
		lo = bp_mem[0] * 256;
		hi = bp_mem[n-1] * 256;
		sel = $urandom_range(0, 99);
		if (sel < 70 && hi > lo)
			send(mk(KIND_LOOKUP, 0, 0, 0,
				lo + int'($urandom_range(0, hi - lo - 1)),
				lo + int'($urandom_range(0, hi - lo - 1))));
		else if (sel < 82)
			send(mk(KIND_LOOKUP, 0, 0, 0, $urandom, $urandom));
		else if (sel < 96)
			send(mk(2'($urandom_range(1, 2)), $urandom, $urandom, $urandom, $urandom,
				$urandom));
		else if (sel < 98)
			send(mk(KIND_BP, $urandom, 0, $urandom, $urandom, $urandom));
		else
			load_axis(0);
	endtask

	always @(posedge clk) begin
		if (hold_left > 0) begin
			res_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (hold_req && !hold_done) begin
			hold_done <= 1'b1;
			hold_left <= 300;
			res_stall <= 1'b1;
		end else begin
			if (seg_left == 0) begin
				seg_left <= $urandom_range(20, 200);
				seg_mode <= $urandom_range(0, 2);
			end else begin
				seg_left <= seg_left - 1;
			end
			case (seg_mode)
				0: res_stall <= 1'b0;
				1: res_stall <= $urandom_range(0, 3) == 0;
				default: res_stall <= $urandom_range(0, 1);
			endcase
		end

		if (res_valid && !res_stall) begin
			if (lookup_q.size() == 0) begin
				$error("result with nothing expected: in_range=%0d out_x=%0d out_y=%0d",
					res.in_range, res.out_x, res.out_y);
				errs++;
			end else begin
				result_t w;
				w = lookup_q.pop_front();
				if (res.in_range !== w.in_range) begin
					$error("in_range: expected %0d, got %0d", w.in_range, res.in_range);
					errs++;
				end
				if (res.out_x !== w.out_x) begin
					$error("out_x: expected %0d, got %0d", w.out_x, res.out_x);
					errs++;
				end
				if (res.out_y !== w.out_y) begin
					$error("out_y: expected %0d, got %0d", w.out_y, res.out_y);
					errs++;
				end
			end
		end
	end

	initial begin
		result_t none;
		int mid;
		logic [4:0]  pts_set [] = '{5'd2, 5'd0, 5'd31, 5'd1, 5'd8, 5'd16};
		logic [15:0] res_set [] = '{16'd0, 16'd65535, 16'd1, 16'd256, 16'd40000, 16'd65535};

		none = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// every entry is loaded before any lookup reads it
		load_axis(1);
		for (int r = 0; r < NPTS; r++)
			for (int c = 0; c < NPTS; c++) begin
				send(mk(KIND_XTAB, r, c, $urandom, 0, 0));
				send(mk(KIND_YTAB, r, c, $urandom, 0, 0));
			end

		// grid is -120..105 step 15 here
		mid = -20 * 256 + 77;
		dir_rows.push_back('{mk(KIND_LOOKUP, 0, 0, 0, -32768, -32768), 1, none});
		dir_rows.push_back('{mk(KIND_LOOKUP, 0, 0, 0, 32767, 32767), 1, none});
		dir_rows.push_back('{mk(KIND_LOOKUP, 0, 0, 0, -120*256 - 1, mid), 1, none});
		dir_rows.push_back('{mk(KIND_LOOKUP, 0, 0, 0, mid, 105*256), 1, none});
		dir_rows.push_back('{mk(KIND_LOOKUP, 0, 0, 0, -120*256, -120*256), 0, none});
		dir_rows.push_back('{mk(KIND_LOOKUP, 0, 0, 0, 105*256 - 1, 105*256 - 1), 0, none});
		dir_rows.push_back('{mk(KIND_LOOKUP, 0, 0, 0, mid, -mid), 0, none});
		dir_rows.push_back('{mk(KIND_XTAB, 0, 0, 127, 0, 0), 0, none});
		dir_rows.push_back('{mk(KIND_YTAB, 0, 0, -128, 0, 0), 0, none});
		dir_rows.push_back('{mk(KIND_XTAB, 15, 15, -128, 0, 0), 0, none});
		dir_rows.push_back('{mk(KIND_YTAB, 15, 15, 127, 0, 0), 0, none});
		dir_rows.push_back('{mk(KIND_XTAB, 15, 14, 127, 0, 0), 0, none});
		dir_rows.push_back('{mk(KIND_LOOKUP, 0, 0, 0, -120*256 + 128, -120*256 + 3), 0, none});
		dir_rows.push_back('{mk(KIND_LOOKUP, 0, 0, 0, 105*256 - 9, 105*256 - 200), 0, none});
		// breakpoints out of order: bracket search picks the last one at or below floor
		dir_rows.push_back('{mk(KIND_BP, 5, 0, -100, 0, 0), 0, none});
		dir_rows.push_back('{mk(KIND_LOOKUP, 0, 0, 0, -55*256, -40*256 + 5), 0, none});
		dir_rows.push_back('{mk(KIND_LOOKUP, 0, 0, 0, -95*256 + 1, -62*256), 0, none});
		dir_rows.push_back('{mk(KIND_BP, 5, 0, -45, 0, 0), 0, none});
		dir_rows.push_back('{mk(KIND_LOOKUP, 0, 0, 0, -32768, 32767), 1, none});
		foreach (dir_rows[k])
			send(dir_rows[k].it, dir_rows[k].known, dir_rows[k].want);

		drain();
		foreach (pts_set[p]) begin
			write_reg(REG_POINTS, {11'd0, pts_set[p]});
			write_reg(REG_RES, res_set[p]);
			for (int k = 0; k < RAND_ITEMS / 6; k++) begin
				if (p == 2 && k == 40)
					hold_req <= 1'b1;
				rand_item();
			end
			drain();
		end

		if (errs == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end
endmodule

// ===== files.f =====
+incdir+src
src/btint_pkg.sv
src/btint_ctrl.sv
src/btint_dp.sv
src/bilinear_table_interpolator_core.sv
test/tb_top.sv
